// ===== hw/rtl/spq_pkg.sv =====
package spq_pkg;

    localparam int DATA_W       = 32;
    localparam int PRIO_PORT_W  = 8;
    localparam int COUNT_PORT_W = 5;
    localparam int STATUS_W     = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } t_command;

    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_ctrl;

endpackage

// ===== hw/rtl/stable_priority_queue.sv =====
// Channel  | Valid    | Stall    | Word
// ---------+----------+----------+--------------------------------------------------
// command  | i_valid  | o_stall  | i_command, i_item_data, i_item_priority
// result   | o_valid  | i_stall  | o_status, o_removed_data, o_removed_priority,
//          |          |          | o_head_data, o_head_priority, o_entry_count, o_is_empty
//
// Every cell compares and shifts at once, so a new word is accepted in every cycle in
// which the result register is free or being emptied.
// The result is registered and appears in the cycle after its word is accepted.
// Reset clears the entry count and the result valid flag; the cells and the result fields
// need no reset.
// A stall on the result side stalls the command side only while a result is waiting.
module stable_priority_queue #(
    parameter int CAPACITY      = 16,
    parameter int PRIORITY_BITS = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic                                   i_command,
    input  logic signed [spq_pkg::DATA_W-1:0]      i_item_data,
    input  logic [spq_pkg::PRIO_PORT_W-1:0]        i_item_priority,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic [spq_pkg::STATUS_W-1:0]           o_status,
    output logic signed [spq_pkg::DATA_W-1:0]      o_removed_data,
    output logic [spq_pkg::PRIO_PORT_W-1:0]        o_removed_priority,
    output logic signed [spq_pkg::DATA_W-1:0]      o_head_data,
    output logic [spq_pkg::PRIO_PORT_W-1:0]        o_head_priority,
    output logic [spq_pkg::COUNT_PORT_W-1:0]       o_entry_count,
    output logic                                   o_is_empty
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                        w_accept;
    logic                        w_full;
    logic                        w_empty;
    spq_pkg::t_cell_ctrl         w_ctrl;
    spq_pkg::t_status            w_status;
    logic [PRIORITY_BITS-1:0]    w_new_pri;
    logic [CNT_W-1:0]            n_count;
    logic [CNT_W-1:0]            r_count;

    logic                        w_keep      [CAPACITY];
    logic [spq_pkg::DATA_W-1:0]  w_data      [CAPACITY];
    logic [PRIORITY_BITS-1:0]    w_pri       [CAPACITY];
    logic [spq_pkg::DATA_W-1:0]  w_next_data [CAPACITY];
    logic [PRIORITY_BITS-1:0]    w_next_pri  [CAPACITY];

    logic                        r_valid;
    spq_pkg::t_status            r_status;
    logic [spq_pkg::DATA_W-1:0]  r_removed_data;
    logic [PRIORITY_BITS-1:0]    r_removed_pri;
    logic [spq_pkg::DATA_W-1:0]  r_head_data;
    logic [PRIORITY_BITS-1:0]    r_head_pri;
    logic [CNT_W-1:0]            r_out_count;

    assign o_stall   = r_valid && i_stall;
    assign w_accept  = i_valid && !o_stall;
    assign w_full    = (r_count == CNT_W'(CAPACITY));
    assign w_empty   = (r_count == '0);
    assign w_new_pri = PRIORITY_BITS'(i_item_priority);

    always_comb begin
        w_ctrl.ins = w_accept && (i_command == spq_pkg::CMD_INSERT) && !w_full;
        w_ctrl.rem = w_accept && (i_command == spq_pkg::CMD_REMOVE) && !w_empty;
        n_count    = r_count;
        w_status   = spq_pkg::ST_DONE;
        if (w_ctrl.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctrl.rem) begin
            n_count = r_count - CNT_W'(1);
        end
        if (i_command == spq_pkg::CMD_INSERT) begin
            if (w_full) begin
                w_status = spq_pkg::ST_FULL;
            end
        end else if (w_empty) begin
            w_status = spq_pkg::ST_EMPTY;
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                       w_occupied;
        logic                       w_left_keep;
        logic [spq_pkg::DATA_W-1:0] w_left_data;
        logic [PRIORITY_BITS-1:0]   w_left_pri;
        logic [spq_pkg::DATA_W-1:0] w_right_data;
        logic [PRIORITY_BITS-1:0]   w_right_pri;

        assign w_occupied = (CNT_W'(g) < r_count);

        if (g == 0) begin : g_first
            assign w_left_keep = 1'b1;
            assign w_left_data = i_item_data;
            assign w_left_pri  = w_new_pri;
        end else begin : g_inner
            assign w_left_keep = w_keep[g-1];
            assign w_left_data = w_data[g-1];
            assign w_left_pri  = w_pri[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right_data = w_data[g];
            assign w_right_pri  = w_pri[g];
        end else begin : g_mid
            assign w_right_data = w_data[g+1];
            assign w_right_pri  = w_pri[g+1];
        end

        spq_cell #(
            .PRIORITY_BITS(PRIORITY_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_occupied   (w_occupied),
            .i_new_data   (i_item_data),
            .i_new_pri    (w_new_pri),
            .i_left_keep  (w_left_keep),
            .i_left_data  (w_left_data),
            .i_left_pri   (w_left_pri),
            .i_right_data (w_right_data),
            .i_right_pri  (w_right_pri),
            .o_keep       (w_keep[g]),
            .o_data       (w_data[g]),
            .o_pri        (w_pri[g]),
            .o_next_data  (w_next_data[g]),
            .o_next_pri   (w_next_pri[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_status       <= w_status;
            r_removed_data <= w_ctrl.rem ? w_data[0] : '0;
            r_removed_pri  <= w_ctrl.rem ? w_pri[0] : '0;
            r_head_data    <= (n_count != '0) ? w_next_data[0] : '0;
            r_head_pri     <= (n_count != '0) ? w_next_pri[0] : '0;
            r_out_count    <= n_count;
        end
    end

    assign o_valid            = r_valid;
    assign o_status           = r_status;
    assign o_removed_data     = r_removed_data;
    assign o_removed_priority = spq_pkg::PRIO_PORT_W'(r_removed_pri);
    assign o_head_data        = r_head_data;
    assign o_head_priority    = spq_pkg::PRIO_PORT_W'(r_head_pri);
    assign o_entry_count      = spq_pkg::COUNT_PORT_W'(r_out_count);
    assign o_is_empty         = (r_out_count == '0);

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_full_drop : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_command == spq_pkg::CMD_INSERT && w_full)
        |=> (r_status == spq_pkg::ST_FULL) && (r_count == CNT_W'(CAPACITY)))
        else $error("insert into a full queue was not dropped");

    a_insert_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.ins |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not add one entry");

    a_remove_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.rem |=> (r_count == $past(r_count) - CNT_W'(1)) && (r_out_count == r_count))
        else $error("remove did not take one entry");

endmodule

// ===== hw/rtl/spq_cell.sv =====
module spq_cell #(
    parameter int PRIORITY_BITS = 8
) (
    input  logic                       i_clk,
    input  spq_pkg::t_cell_ctrl        i_ctrl,
    input  logic                       i_occupied,
    input  logic [spq_pkg::DATA_W-1:0] i_new_data,
    input  logic [PRIORITY_BITS-1:0]   i_new_pri,
    input  logic                       i_left_keep,
    input  logic [spq_pkg::DATA_W-1:0] i_left_data,
    input  logic [PRIORITY_BITS-1:0]   i_left_pri,
    input  logic [spq_pkg::DATA_W-1:0] i_right_data,
    input  logic [PRIORITY_BITS-1:0]   i_right_pri,
    output logic                       o_keep,
    output logic [spq_pkg::DATA_W-1:0] o_data,
    output logic [PRIORITY_BITS-1:0]   o_pri,
    output logic [spq_pkg::DATA_W-1:0] o_next_data,
    output logic [PRIORITY_BITS-1:0]   o_next_pri
);

    logic [spq_pkg::DATA_W-1:0] r_data;
    logic [PRIORITY_BITS-1:0]   r_pri;
    logic [spq_pkg::DATA_W-1:0] n_data;
    logic [PRIORITY_BITS-1:0]   n_pri;

    // An entry stays put on insert when it ranks at or ahead of the new one.
    assign o_keep = i_occupied && (r_pri <= i_new_pri);

    always_comb begin
        n_data = r_data;
        n_pri  = r_pri;
        if (i_ctrl.ins && !o_keep) begin
            if (i_left_keep) begin
                n_data = i_new_data;
                n_pri  = i_new_pri;
            end else begin
                n_data = i_left_data;
                n_pri  = i_left_pri;
            end
        end else if (i_ctrl.rem) begin
            n_data = i_right_data;
            n_pri  = i_right_pri;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_pri  <= n_pri;
    end

    assign o_data      = r_data;
    assign o_pri       = r_pri;
    assign o_next_data = n_data;
    assign o_next_pri  = n_pri;

endmodule

// ===== tb/tb_stable_priority_queue.sv =====
`timescale 1ns / 1ps

module tb_stable_priority_queue;

    import spq_pkg::*;

    localparam int QUEUE_DEPTH   = 16;
    localparam int RANDOM_WORDS  = 1250;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct packed {
        t_status                   status;
        logic signed [DATA_W-1:0]  removed_data;
        logic [PRIO_PORT_W-1:0]    removed_priority;
        logic signed [DATA_W-1:0]  head_data;
        logic [PRIO_PORT_W-1:0]    head_priority;
        logic [COUNT_PORT_W-1:0]   entry_count;
        logic                      is_empty;
    } t_outcome;

    typedef struct {
        t_command                  cmd;
        logic signed [DATA_W-1:0]  data;
        logic [PRIO_PORT_W-1:0]    prio;
        bit                        typed;
        t_outcome                  outcome;
    } t_stim_row;

    localparam t_outcome NO_OUTCOME = '{ST_DONE, 0, 0, 0, 0, 0, 1'b0};

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_stall;
    logic                          i_command;
    logic signed [DATA_W-1:0]      i_item_data;
    logic [PRIO_PORT_W-1:0]        i_item_priority;
    logic                          o_valid;
    logic                          i_stall;
    logic [STATUS_W-1:0]           o_status;
    logic signed [DATA_W-1:0]      o_removed_data;
    logic [PRIO_PORT_W-1:0]        o_removed_priority;
    logic signed [DATA_W-1:0]      o_head_data;
    logic [PRIO_PORT_W-1:0]        o_head_priority;
    logic [COUNT_PORT_W-1:0]       o_entry_count;
    logic                          o_is_empty;

    logic signed [DATA_W-1:0]      held_data [QUEUE_DEPTH];
    logic [PRIO_PORT_W-1:0]        held_prio [QUEUE_DEPTH];
    int                            held_count;

    t_outcome                      expected_outcomes [$];
    t_outcome                      next_outcome;
    t_stim_row                     directed_rows [$];
    int                            error_count;
    int                            cycle_count;
    int                            stall_left;
    bit                            receiver_quiet;
    bit                            sender_quiet;

    stable_priority_queue i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_command          (i_command),
        .i_item_data        (i_item_data),
        .i_item_priority    (i_item_priority),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_status           (o_status),
        .o_removed_data     (o_removed_data),
        .o_removed_priority (o_removed_priority),
        .o_head_data        (o_head_data),
        .o_head_priority    (o_head_priority),
        .o_entry_count      (o_entry_count),
        .o_is_empty         (o_is_empty)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_outcome sorted_queue_step(input t_command cmd,
            input logic signed [DATA_W-1:0] data, input logic [PRIO_PORT_W-1:0] prio);
        t_outcome res;
        int pos;
        res = NO_OUTCOME;
        if (cmd == CMD_INSERT) begin
            if (held_count >= QUEUE_DEPTH) begin
                res.status = ST_FULL;
            end else begin
                pos = 0;
                while (pos < held_count && held_prio[pos] <= prio) pos++;
                for (int i = held_count; i > pos; i--) begin
                    held_data[i] = held_data[i-1];
                    held_prio[i] = held_prio[i-1];
                end
                held_data[pos] = data;
                held_prio[pos] = prio;
                held_count++;
            end
        end else begin
            if (held_count == 0) begin
                res.status = ST_EMPTY;
            end else begin
                res.removed_data     = held_data[0];
                res.removed_priority = held_prio[0];
                for (int i = 1; i < held_count; i++) begin
                    held_data[i-1] = held_data[i];
                    held_prio[i-1] = held_prio[i];
                end
                held_count--;
            end
        end
        if (held_count != 0) begin
            res.head_data     = held_data[0];
            res.head_priority = held_prio[0];
        end
        res.entry_count = COUNT_PORT_W'(held_count);
        res.is_empty    = (held_count == 0);
        return res;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (sender_quiet || roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
            input logic [31:0] want);
        error_count++;
        $display("mismatch in %s at cycle %0d: got %0h, expected %0h",
                 what, cycle_count, got, want);
    endtask

    task automatic send_word(input t_command cmd, input logic signed [DATA_W-1:0] data,
            input logic [PRIO_PORT_W-1:0] prio, input bit typed, input t_outcome typed_outcome);
        t_outcome predicted;
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid         = 1'b1;
        i_command       = cmd;
        i_item_data     = data;
        i_item_priority = prio;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predicted = sorted_queue_step(cmd, data, prio);
        expected_outcomes.push_back(typed ? typed_outcome : predicted);
        @(negedge i_clk);
    endtask

    initial begin
        i_stall        = 1'b0;
        stall_left     = 0;
        receiver_quiet = 1'b0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 199) == 0) receiver_quiet = ~receiver_quiet;
            if (stall_left > 0) begin
                stall_left--;
                i_stall = 1'b1;
            end else begin
                i_stall = 1'b0;
                if (!receiver_quiet && $urandom_range(0, 99) < 25) begin
                    stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                             : $urandom_range(1, 3);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_stable_priority_queue: done, errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_outcomes.size() == 0) begin
                report_mismatch("unexpected word", o_status, 0);
            end else begin
                next_outcome = expected_outcomes.pop_front();
                if (o_status !== next_outcome.status)
                    report_mismatch("status", o_status, next_outcome.status);
                if (o_removed_data !== next_outcome.removed_data)
                    report_mismatch("removed_data", o_removed_data, next_outcome.removed_data);
                if (o_removed_priority !== next_outcome.removed_priority)
                    report_mismatch("removed_priority", o_removed_priority,
                                    next_outcome.removed_priority);
                if (o_head_data !== next_outcome.head_data)
                    report_mismatch("head_data", o_head_data, next_outcome.head_data);
                if (o_head_priority !== next_outcome.head_priority)
                    report_mismatch("head_priority", o_head_priority,
                                    next_outcome.head_priority);
                if (o_entry_count !== next_outcome.entry_count)
                    report_mismatch("entry_count", o_entry_count, next_outcome.entry_count);
                if (o_is_empty !== next_outcome.is_empty)
                    report_mismatch("is_empty", o_is_empty, next_outcome.is_empty);
            end
        end
    end

    initial begin
        t_stim_row row;
        int random_sent;
        int burst_left;
        int insert_pct;
        int prio_mode;
        logic [PRIO_PORT_W-1:0] prio;
        t_command cmd;

        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_command       = CMD_INSERT;
        i_item_data     = '0;
        i_item_priority = '0;
        held_count      = 0;
        error_count     = 0;
        cycle_count     = 0;
        sender_quiet    = 1'b0;

        // Empty queue, extreme words, equal priorities kept in arrival order.
        directed_rows.push_back('{CMD_REMOVE, 32'sd0, 8'd0, 1'b1,
                                  '{ST_EMPTY, 0, 0, 0, 0, 5'd0, 1'b1}});
        directed_rows.push_back('{CMD_INSERT, 32'h7fffffff, 8'd255, 1'b1,
                                  '{ST_DONE, 0, 0, 32'h7fffffff, 8'd255, 5'd1, 1'b0}});
        directed_rows.push_back('{CMD_INSERT, 32'h80000000, 8'd0, 1'b1,
                                  '{ST_DONE, 0, 0, 32'h80000000, 8'd0, 5'd2, 1'b0}});
        directed_rows.push_back('{CMD_INSERT, 32'sd5, 8'd0, 1'b1,
                                  '{ST_DONE, 0, 0, 32'h80000000, 8'd0, 5'd3, 1'b0}});
        directed_rows.push_back('{CMD_REMOVE, 32'hffffffff, 8'd255, 1'b1,
                                  '{ST_DONE, 32'h80000000, 8'd0, 32'sd5, 8'd0, 5'd2, 1'b0}});
        // Fill the queue to capacity, then try to overfill it.
        directed_rows.push_back('{CMD_INSERT, 32'h00000011, 8'd255, 1'b0, NO_OUTCOME});
        directed_rows.push_back('{CMD_INSERT, 32'h00000022, 8'd0, 1'b0, NO_OUTCOME});
        directed_rows.push_back('{CMD_INSERT, 32'h00000033, 8'd128, 1'b0, NO_OUTCOME});
        directed_rows.push_back('{CMD_INSERT, 32'hdeadbeef, 8'd1, 1'b0, NO_OUTCOME});
        directed_rows.push_back('{CMD_INSERT, 32'h55555555, 8'd254, 1'b0, NO_OUTCOME});
        directed_rows.push_back('{CMD_INSERT, 32'haaaaaaaa, 8'd128, 1'b0, NO_OUTCOME});
        directed_rows.push_back('{CMD_INSERT, 32'h00000077, 8'd0, 1'b0, NO_OUTCOME});
        directed_rows.push_back('{CMD_INSERT, 32'h0f0f0f0f, 8'd7, 1'b0, NO_OUTCOME});
        directed_rows.push_back('{CMD_INSERT, 32'hf0f0f0f0, 8'd255, 1'b0, NO_OUTCOME});
        directed_rows.push_back('{CMD_INSERT, 32'h12345678, 8'd64, 1'b0, NO_OUTCOME});
        directed_rows.push_back('{CMD_INSERT, 32'h87654321, 8'd128, 1'b0, NO_OUTCOME});
        directed_rows.push_back('{CMD_INSERT, 32'h00000000, 8'd3, 1'b0, NO_OUTCOME});
        directed_rows.push_back('{CMD_INSERT, 32'hffffffff, 8'd200, 1'b0, NO_OUTCOME});
        directed_rows.push_back('{CMD_INSERT, 32'h000000aa, 8'd0, 1'b0, NO_OUTCOME});
        directed_rows.push_back('{CMD_INSERT, 32'h00001234, 8'd0, 1'b1,
                                  '{ST_FULL, 0, 0, 32'sd5, 8'd0, 5'd16, 1'b0}});
        directed_rows.push_back('{CMD_INSERT, 32'hffffffff, 8'd255, 1'b1,
                                  '{ST_FULL, 0, 0, 32'sd5, 8'd0, 5'd16, 1'b0}});
        directed_rows.push_back('{CMD_REMOVE, 32'sd0, 8'd0, 1'b0, NO_OUTCOME});
        directed_rows.push_back('{CMD_REMOVE, 32'sd0, 8'd0, 1'b0, NO_OUTCOME});

        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[n]) begin
            row = directed_rows[n];
            send_word(row.cmd, row.data, row.prio, row.typed, row.outcome);
        end

        // Bursts lean towards filling or draining so that both ends are reached often.
        random_sent = 0;
        burst_left  = 0;
        insert_pct  = 50;
        prio_mode   = 0;
        while (random_sent < RANDOM_WORDS) begin
            if (burst_left == 0) begin
                burst_left   = $urandom_range(25, 75);
                insert_pct   = ($urandom_range(0, 2) == 0) ? 85 :
                               ($urandom_range(0, 1) == 0) ? 15 : 50;
                prio_mode    = $urandom_range(0, 2);
                sender_quiet = ($urandom_range(0, 3) == 0);
            end
            cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
            case (prio_mode)
                0: begin
                    prio = PRIO_PORT_W'($urandom_range(0, 255));
                end
                1: begin
                    prio = PRIO_PORT_W'($urandom_range(0, 3));
                end
                default: begin
                    prio = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255;
                end
            endcase
            send_word(cmd, $urandom, prio, 1'b0, NO_OUTCOME);
            random_sent++;
            burst_left--;
        end
        i_valid = 1'b0;

        while (expected_outcomes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_stable_priority_queue: done, clean");
        end else begin
            $display("tb_stable_priority_queue: done, errors");
        end
        $finish;
    end

endmodule
